[hw/rtl/segi_pkg.sv]
// Shared constants and types for the segment intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package segi_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	typedef struct packed {
		logic valid;
		logic hit;
		logic parallel;
		logic neg_x;
		logic neg_y;
	} segi_tag_t;

endpackage
`default_nettype wire

[hw/rtl/segi_in_if.sv]
// Input channel carrying one pair of segments per beat.
`timescale 1ns / 1ps
`default_nettype none
interface segi_in_if #(
	parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF
);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] first_x_start;
	logic signed [COORD_BITS-1:0] first_y_start;
	logic signed [COORD_BITS-1:0] first_x_end;
	logic signed [COORD_BITS-1:0] first_y_end;
	logic signed [COORD_BITS-1:0] second_x_start;
	logic signed [COORD_BITS-1:0] second_y_start;
	logic signed [COORD_BITS-1:0] second_x_end;
	logic signed [COORD_BITS-1:0] second_y_end;

	modport source (
		output valid, first_x_start, first_y_start, first_x_end, first_y_end,
		output second_x_start, second_y_start, second_x_end, second_y_end,
		input ready
	);
	modport sink (
		input valid, first_x_start, first_y_start, first_x_end, first_y_end,
		input second_x_start, second_y_start, second_x_end, second_y_end,
		output ready
	);
endinterface
`default_nettype wire

[hw/rtl/segi_out_if.sv]
// Output channel carrying one intersection result per beat.
`timescale 1ns / 1ps
`default_nettype none
interface segi_out_if #(
	parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF
);
	logic valid;
	logic ready;
	logic hit;
	logic parallel;
	logic signed [COORD_BITS+FRAC_BITS-1:0] cross_x;
	logic signed [COORD_BITS+FRAC_BITS-1:0] cross_y;

	modport source (output valid, hit, parallel, cross_x, cross_y, input ready);
	modport sink (input valid, hit, parallel, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

[hw/rtl/segment_intersection.sv]
// Top level of the segment intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Intersects two line segments per beat by Cramer's rule on the implicit line
// equations. A zero determinant reports parallel lines. Otherwise the crossing
// is range checked exactly against both segments, and on a hit it is divided
// out to signed fixed point with FRAC_BITS fraction bits, truncated toward zero.
// One pair is accepted in every cycle unless the result side stalls. The pipeline
// has seven arithmetic stages, one divider stage per quotient bit, and the output
// register. A stall on the result side holds the whole pipeline.
module segment_intersection #(
	parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	segi_in_if.sink    pair,
	segi_out_if.source result
);
	localparam int W     = COORD_BITS;
	localparam int AW    = W + 1;
	localparam int CW    = 2 * W + 2;
	localparam int DTW   = 2 * W + 3;
	localparam int DW    = 2 * W + 2;
	localparam int RW    = 3 * W + 3;
	localparam int NUM_W = 3 * W + 4;
	localparam int QW    = W + FRAC_BITS;
	localparam int NW    = NUM_W + FRAC_BITS;

	logic en;
	logic out_v_q;

	assign en         = !out_v_q || result.ready;
	assign pair.ready = en && arst_n;

	// Stage 1: line coefficients A and B.
	logic v_s1;
	logic signed [W-1:0]  x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= pair.first_x_start;
			y1_s1 <= pair.first_y_start;
			x2_s1 <= pair.first_x_end;
			y2_s1 <= pair.first_y_end;
			x3_s1 <= pair.second_x_start;
			y3_s1 <= pair.second_y_start;
			x4_s1 <= pair.second_x_end;
			y4_s1 <= pair.second_y_end;
			a1_s1 <= AW'(pair.first_y_end) - AW'(pair.first_y_start);
			b1_s1 <= AW'(pair.first_x_start) - AW'(pair.first_x_end);
			a2_s1 <= AW'(pair.second_y_end) - AW'(pair.second_y_start);
			b2_s1 <= AW'(pair.second_x_start) - AW'(pair.second_x_end);
		end
	end

	// Stage 2: products for C and the determinant.
	logic v_s2;
	logic signed [W-1:0]  x1_s2, y1_s2, x2_s2, y2_s2, x3_s2, y3_s2, x4_s2, y4_s2;
	logic signed [AW-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [CW-1:0] ax1_s2, by1_s2, ax3_s2, by3_s2, ab_s2, ba_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2 <= x1_s1; y1_s2 <= y1_s1; x2_s2 <= x2_s1; y2_s2 <= y2_s1;
			x3_s2 <= x3_s1; y3_s2 <= y3_s1; x4_s2 <= x4_s1; y4_s2 <= y4_s1;
			a1_s2 <= a1_s1; b1_s2 <= b1_s1; a2_s2 <= a2_s1; b2_s2 <= b2_s1;
			ax1_s2 <= CW'(a1_s1) * CW'(x1_s1);
			by1_s2 <= CW'(b1_s1) * CW'(y1_s1);
			ax3_s2 <= CW'(a2_s1) * CW'(x3_s1);
			by3_s2 <= CW'(b2_s1) * CW'(y3_s1);
			ab_s2  <= CW'(a1_s1) * CW'(b2_s1);
			ba_s2  <= CW'(a2_s1) * CW'(b1_s1);
		end
	end

	// Stage 3: C values and the determinant.
	logic v_s3;
	logic signed [W-1:0]   x1_s3, y1_s3, x2_s3, y2_s3, x3_s3, y3_s3, x4_s3, y4_s3;
	logic signed [AW-1:0]  a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [CW-1:0]  c1_s3, c2_s3;
	logic signed [DTW-1:0] det_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s3 <= x1_s2; y1_s3 <= y1_s2; x2_s3 <= x2_s2; y2_s3 <= y2_s2;
			x3_s3 <= x3_s2; y3_s3 <= y3_s2; x4_s3 <= x4_s2; y4_s3 <= y4_s2;
			a1_s3 <= a1_s2; b1_s3 <= b1_s2; a2_s3 <= a2_s2; b2_s3 <= b2_s2;
			c1_s3  <= ax1_s2 + by1_s2;
			c2_s3  <= ax3_s2 + by3_s2;
			det_s3 <= DTW'(ab_s2) - DTW'(ba_s2);
		end
	end

	// Stage 4: numerator products.
	logic v_s4;
	logic signed [W-1:0]     x1_s4, y1_s4, x2_s4, y2_s4, x3_s4, y3_s4, x4_s4, y4_s4;
	logic signed [DTW-1:0]   det_s4;
	logic signed [NUM_W-1:0] bc1_s4, bc2_s4, ac1_s4, ac2_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s4 <= x1_s3; y1_s4 <= y1_s3; x2_s4 <= x2_s3; y2_s4 <= y2_s3;
			x3_s4 <= x3_s3; y3_s4 <= y3_s3; x4_s4 <= x4_s3; y4_s4 <= y4_s3;
			det_s4 <= det_s3;
			bc1_s4 <= NUM_W'(b2_s3) * NUM_W'(c1_s3);
			bc2_s4 <= NUM_W'(b1_s3) * NUM_W'(c2_s3);
			ac1_s4 <= NUM_W'(a1_s3) * NUM_W'(c2_s3);
			ac2_s4 <= NUM_W'(a2_s3) * NUM_W'(c1_s3);
		end
	end

	// Stage 5: numerators, with the sign of the determinant folded in.
	logic v_s5;
	logic signed [W-1:0]     x1_s5, y1_s5, x2_s5, y2_s5, x3_s5, y3_s5, x4_s5, y4_s5;
	logic [DW-1:0]           det_s5;
	logic                    par_s5;
	logic signed [NUM_W-1:0] nx_s5, ny_s5;
	logic signed [NUM_W-1:0] nx_raw, ny_raw;
	logic signed [DTW-1:0]   det_neg;

	assign nx_raw  = bc1_s4 - bc2_s4;
	assign ny_raw  = ac1_s4 - ac2_s4;
	assign det_neg = -det_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s5 <= x1_s4; y1_s5 <= y1_s4; x2_s5 <= x2_s4; y2_s5 <= y2_s4;
			x3_s5 <= x3_s4; y3_s5 <= y3_s4; x4_s5 <= x4_s4; y4_s5 <= y4_s4;
			par_s5 <= (det_s4 == '0);
			det_s5 <= det_s4[DTW-1] ? det_neg[DW-1:0] : det_s4[DW-1:0];
			nx_s5  <= det_s4[DTW-1] ? -nx_raw : nx_raw;
			ny_s5  <= det_s4[DTW-1] ? -ny_raw : ny_raw;
		end
	end

	// Stage 6: range bounds scaled by the determinant.
	logic v_s6;
	logic [DW-1:0]           det_s6;
	logic                    par_s6;
	logic signed [NUM_W-1:0] nx_s6, ny_s6;
	logic signed [RW-1:0]    lx1_s6, hx1_s6, ly1_s6, hy1_s6;
	logic signed [RW-1:0]    lx2_s6, hx2_s6, ly2_s6, hy2_s6;
	logic signed [RW-1:0]    det_ext;

	assign det_ext = RW'($signed({1'b0, det_s5}));

	always_ff @(posedge clk) begin
		if (en) begin
			det_s6 <= det_s5;
			par_s6 <= par_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			lx1_s6 <= RW'((x1_s5 < x2_s5) ? x1_s5 : x2_s5) * det_ext;
			hx1_s6 <= RW'((x1_s5 < x2_s5) ? x2_s5 : x1_s5) * det_ext;
			ly1_s6 <= RW'((y1_s5 < y2_s5) ? y1_s5 : y2_s5) * det_ext;
			hy1_s6 <= RW'((y1_s5 < y2_s5) ? y2_s5 : y1_s5) * det_ext;
			lx2_s6 <= RW'((x3_s5 < x4_s5) ? x3_s5 : x4_s5) * det_ext;
			hx2_s6 <= RW'((x3_s5 < x4_s5) ? x4_s5 : x3_s5) * det_ext;
			ly2_s6 <= RW'((y3_s5 < y4_s5) ? y3_s5 : y4_s5) * det_ext;
			hy2_s6 <= RW'((y3_s5 < y4_s5) ? y4_s5 : y3_s5) * det_ext;
		end
	end

	// Stage 7: range tests and divider operands.
	logic                 v_s7;
	segi_pkg::segi_tag_t  tag_s7;
	logic [NW-1:0]        numx_s7, numy_s7;
	logic [DW-1:0]        det_s7;
	logic                 ok1, ok2;
	logic [NUM_W-1:0]     magx, magy;

	assign ok1 = (nx_s6 >= NUM_W'(lx1_s6) && nx_s6 <= NUM_W'(hx1_s6)) ||
		(ny_s6 >= NUM_W'(ly1_s6) && ny_s6 <= NUM_W'(hy1_s6));
	assign ok2 = (nx_s6 >= NUM_W'(lx2_s6) && nx_s6 <= NUM_W'(hx2_s6)) ||
		(ny_s6 >= NUM_W'(ly2_s6) && ny_s6 <= NUM_W'(hy2_s6));
	assign magx = nx_s6[NUM_W-1] ? NUM_W'(-nx_s6) : NUM_W'(nx_s6);
	assign magy = ny_s6[NUM_W-1] ? NUM_W'(-ny_s6) : NUM_W'(ny_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			det_s7          <= det_s6;
			numx_s7         <= NW'(magx) << FRAC_BITS;
			numy_s7         <= NW'(magy) << FRAC_BITS;
			tag_s7.valid    <= v_s6;
			tag_s7.hit      <= !par_s6 && ok1 && ok2;
			tag_s7.parallel <= par_s6;
			tag_s7.neg_x    <= nx_s6[NUM_W-1];
			tag_s7.neg_y    <= ny_s6[NUM_W-1];
		end
	end

	// Valid bits of the arithmetic stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair.valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	// Divider stages with the matching tag line.
	logic [QW-1:0] qx, qy;
	segi_pkg::segi_tag_t tag_d [QW];
	segi_pkg::segi_tag_t tag_in;

	always_comb begin
		tag_in       = tag_s7;
		tag_in.valid = v_s7;
	end

	segi_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
		.clk (clk), .en (en), .num (numx_s7), .den (det_s7), .quo (qx)
	);
	segi_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
		.clk (clk), .en (en), .num (numy_s7), .den (det_s7), .quo (qy)
	);

	for (genvar k = 0; k < QW; k++) begin : g_tag
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_d[k] <= '0;
			end else if (en) begin
				tag_d[k] <= (k == 0) ? tag_in : tag_d[(k == 0) ? 0 : k-1];
			end
		end
	end

	// Output register.
	segi_pkg::segi_tag_t tag_last;
	logic [QW-1:0] out_x_q, out_y_q;
	logic          out_hit_q, out_par_q;

	assign tag_last = tag_d[QW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= tag_last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_hit_q <= tag_last.hit;
			out_par_q <= tag_last.parallel;
			out_x_q   <= !tag_last.hit ? '0 : (tag_last.neg_x ? -qx : qx);
			out_y_q   <= !tag_last.hit ? '0 : (tag_last.neg_y ? -qy : qy);
		end
	end

	assign result.valid    = out_v_q;
	assign result.hit      = out_hit_q;
	assign result.parallel = out_par_q;
	assign result.cross_x  = out_x_q;
	assign result.cross_y  = out_y_q;

	// A parallel pair never reports a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.hit && result.parallel))
		else $error("hit and parallel both set");

	// A miss carries a zero crossing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.hit) |-> (result.cross_x == '0 && result.cross_y == '0))
		else $error("nonzero crossing on a miss");

	// The range stage never marks a parallel pair as a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s6 && par_s6) |=> !tag_s7.hit)
		else $error("range stage hit on parallel pair");
endmodule
`default_nettype wire

[hw/rtl/segi_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module segi_div #(
	parameter int NW = 60,
	parameter int DW = 34,
	parameter int QW = 24
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] l_in;
		logic [QW-1:0] q_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in = num[QW +: DW];
			assign d_in = den;
			assign l_in = num[QW-1:0];
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign l_in = low_s[k-1];
			assign q_in = quo_s[k-1];
		end

		assign trial = {r_in, l_in[QW-1]};
		assign diff  = trial - {1'b0, d_in};
		assign ge    = (trial >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_s[k] <= d_in;
				low_s[k] <= l_in << 1;
				quo_s[k] <= (q_in << 1) | QW'(ge);
			end
		end
	end

	assign quo = quo_s[QW-1];
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the segment intersection pipeline.
`timescale 1ns / 1ps
module tb_top;
	localparam int CB = segi_pkg::COORD_BITS_DEF;
	localparam int FB = segi_pkg::FRAC_BITS_DEF;
	localparam int OB = CB + FB;
	localparam int LATENCY = CB + FB + 8;
	localparam int N_RANDOM = 1700;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		logic hit;
		logic parallel;
		logic signed [OB-1:0] cx;
		logic signed [OB-1:0] cy;
	} crossing_t;

	class crossing_board;
		crossing_t pending[$];
		int errors;

		function automatic logic in_range(logic signed [127:0] num, longint det,
				longint a, longint b);
			logic signed [127:0] lo, hi;
			lo = (a < b ? a : b);
			hi = (a < b ? b : a);
			lo = lo * det;
			hi = hi * det;
			return (num >= lo) && (num <= hi);
		endfunction

		function automatic logic signed [OB-1:0] quotient(logic signed [127:0] num,
				longint det);
			logic signed [127:0] q;
			q = (num <<< FB) / det;
			return q[OB-1:0];
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		function void note_pair(coord_t p[8]);
			longint x1, y1, x2, y2, x3, y3, x4, y4;
			longint a1, b1, c1, a2, b2, c2, det;
			logic signed [127:0] nx, ny;
			crossing_t e;
			x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3];
			x3 = p[4]; y3 = p[5]; x4 = p[6]; y4 = p[7];
			a1 = y2 - y1; b1 = x1 - x2; c1 = a1 * x1 + b1 * y1;
			a2 = y4 - y3; b2 = x3 - x4; c2 = a2 * x3 + b2 * y3;
			det = a1 * b2 - a2 * b1;
			e = '{1'b0, 1'b0, '0, '0};
			if (det == 0) begin
				e.parallel = 1'b1;
			end else begin
				nx = 128'(b2) * 128'(c1) - 128'(b1) * 128'(c2);
				ny = 128'(a1) * 128'(c2) - 128'(a2) * 128'(c1);
				if (det < 0) begin
					det = -det;
					nx = -nx;
					ny = -ny;
				end
				if ((in_range(nx, det, x1, x2) || in_range(ny, det, y1, y2)) &&
						(in_range(nx, det, x3, x4) || in_range(ny, det, y3, y4))) begin
					e.hit = 1'b1;
					e.cx = quotient(nx, det);
					e.cy = quotient(ny, det);
				end
			end
			pending.push_back(e);
		endfunction

		task check_result(crossing_t got);
			crossing_t e;
			if (pending.size() == 0) begin
				report_mismatch("result beat with no pair outstanding");
				return;
			end
			e = pending.pop_front();
			if (got.hit !== e.hit)
				report_mismatch($sformatf("hit %b, expected %b", got.hit, e.hit));
			if (got.parallel !== e.parallel)
				report_mismatch($sformatf("parallel %b, expected %b", got.parallel,
					e.parallel));
			if (got.cx !== e.cx)
				report_mismatch($sformatf("cross_x %0d, expected %0d", got.cx, e.cx));
			if (got.cy !== e.cy)
				report_mismatch($sformatf("cross_y %0d, expected %0d", got.cy, e.cy));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int src_idle_pct = 34;
	int snk_idle_pct = 85;
	longint cycles = 0;
	crossing_board board;

	segi_in_if #(.COORD_BITS(CB)) pair_ch();
	segi_out_if #(.COORD_BITS(CB), .FRAC_BITS(FB)) result_ch();

	segment_intersection #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair_ch.sink),
		.result(result_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		pair_ch.valid = 1'b0;
		{pair_ch.first_x_start, pair_ch.first_y_start, pair_ch.first_x_end,
			pair_ch.first_y_end, pair_ch.second_x_start, pair_ch.second_y_start,
			pair_ch.second_x_end, pair_ch.second_y_end} = '0;
		result_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		crossing_t got;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.hit = result_ch.hit;
				got.parallel = result_ch.parallel;
				got.cx = result_ch.cross_x;
				got.cy = result_ch.cross_y;
				board.check_result(got);
			end
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic send_pair(coord_t p[8]);
		while ($urandom_range(99) < src_idle_pct) begin
			pair_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pair_ch.valid <= 1'b1;
		pair_ch.first_x_start <= p[0];
		pair_ch.first_y_start <= p[1];
		pair_ch.first_x_end <= p[2];
		pair_ch.first_y_end <= p[3];
		pair_ch.second_x_start <= p[4];
		pair_ch.second_y_start <= p[5];
		pair_ch.second_x_end <= p[6];
		pair_ch.second_y_end <= p[7];
		@(posedge clk);
		while (!pair_ch.ready)
			@(posedge clk);
		board.note_pair(p);
	endtask

	task automatic send_coords(int a, int b, int c, int d, int e, int f, int g, int h);
		coord_t p[8];
		p = '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d), coord_t'(e),
			coord_t'(f), coord_t'(g), coord_t'(h)};
		send_pair(p);
	endtask

	function automatic coord_t rand_coord(int span);
		if (span == 0)
			return coord_t'($urandom);
		return coord_t'($urandom_range(2 * span) - span);
	endfunction

	task automatic send_random();
		coord_t p[8];
		int span, mode;
		mode = $urandom_range(9);
		span = (mode < 3) ? 0 : (mode < 6 ? 100 : (mode < 8 ? 8 : 2000));
		foreach (p[i])
			p[i] = rand_coord(span);
		if (mode == 9) begin
			p[6] = p[4] + (p[2] - p[0]);
			p[7] = p[5] + (p[3] - p[1]);
		end else if (mode == 8 && $urandom_range(1)) begin
			p[4] = p[0];
			p[5] = p[1];
		end
		send_pair(p);
	endtask

	initial begin
		int phase;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_coords(0, 0, 10, 10, 0, 10, 10, 0);
		send_coords(0, 0, 10, 0, 0, 5, 10, 5);
		send_coords(3, 3, 3, 3, 0, 0, 5, 5);
		send_coords(0, 0, 1, 1, 5, 0, 6, -1);
		send_coords(0, 0, 10, 0, 10, 0, 10, 10);
		send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_coords(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
		send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
		send_coords(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767);
		send_coords(0, 0, 3, 1, 0, 1, 1, 0);
		send_coords(0, 0, -3, 1, 0, 1, -1, 0);
		send_coords(0, 0, 7, 3, 0, 2, 7, -1);
		send_coords(0, 0, 4, 0, 0, 0, 8, 0);
		send_coords(-1, -1, -1, -1, -1, -1, -1, -1);
		send_coords(0, 0, 2, 2, 3, 0, 3, 10);
		send_coords(32767, 0, 32767, 1, -32768, 0, -32767, 1);
		for (phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				src_idle_pct = 85;
				snk_idle_pct = 34;
			end else if (phase == 2) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			repeat (N_RANDOM / 3)
				send_random();
		end
		pair_ch.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
